FILE: src/ilst_pkg.sv
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared types and constants for the indexed list store: command and status
// codes, and the packed words of the command and result channels.
// ----------------------------------------------------------------------------
package ilst_pkg;

    // Field widths of the channel words.
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 5;

    // Default number of list entries.
    localparam int DEFAULT_CAPACITY = 16;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_READ   = 2'd3
    } ilst_cmd_t;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } ilst_status_t;

    // Command word.
    typedef struct packed {
        ilst_cmd_t                  command;
        logic [POS_W-1:0]           position;
        logic signed [DATA_W-1:0]   value;
    } ilst_in_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0]   read_value;
        logic [CNT_OUT_W-1:0]       element_count;
        ilst_status_t               status;
    } ilst_out_t;

endpackage

FILE: src/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Each command word (append, insert at index, remove last, read at index)
// produces exactly one result word with the read value, the element count
// after the command and a status (ok, full, index out of range, empty).
// An insert moves all entries above the insert point up by one cell in the
// same clock, and a read selects one cell onto a shared read bus. The result
// is held in an output register, and a new command is taken in every cycle
// in which that register is empty or being emptied, so the block sustains
// one command per cycle. Commands that cannot be carried out change nothing
// and only report their status.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int CAPACITY = ilst_pkg::DEFAULT_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ilst_pkg::ilst_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ilst_pkg::ilst_out_t m_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int POS_W = ilst_pkg::POS_W;
    localparam int XW    = (CW > POS_W) ? CW : POS_W;
    localparam int CO_W  = ilst_pkg::CNT_OUT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    ilst_pkg::ilst_out_t                m_data_reg;
    ilst_pkg::ilst_out_t                m_data_next;

    logic                               accept;
    logic                               full;
    logic [XW-1:0]                      pos_x;
    logic [XW-1:0]                      cnt_x;
    logic                               wr_en;
    logic [CW-1:0]                      wr_pos;
    logic signed [ilst_pkg::DATA_W-1:0] rd_bus;
    ilst_pkg::ilst_status_t             status;
    logic signed [ilst_pkg::DATA_W-1:0] rd_value;

    logic signed [ilst_pkg::DATA_W-1:0] entry_w [CAPACITY];
    logic signed [ilst_pkg::DATA_W-1:0] rd_w    [CAPACITY];

    // Handshake: the output register frees up when its word is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full  = (count_reg == CAP_C);
    assign pos_x = XW'(s_data.position);
    assign cnt_x = XW'(count_reg);

    // Row of cells; each one sees its lower neighbor's entry.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ilst_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .aclk       (aclk),
            .wr_en      (wr_en),
            .wr_pos     (wr_pos),
            .wr_value   (s_data.value),
            .left_value ((i == 0) ? s_data.value : entry_w[(i == 0) ? 0 : i - 1]),
            .rd_pos     (s_data.position),
            .entry_out  (entry_w[i]),
            .rd_word    (rd_w[i])
        );
    end

    // Gather the read bus; at most one cell drives a nonzero word.
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_bus = rd_bus | rd_w[i];
        end
    end

    // Command decode: status, write request and new count.
    always_comb begin
        status     = ilst_pkg::ST_OK;
        wr_en      = 1'b0;
        wr_pos     = count_reg;
        count_next = count_reg;
        rd_value   = '0;
        case (s_data.command)
            ilst_pkg::CMD_APPEND: begin
                if (full) begin
                    status = ilst_pkg::ST_FULL;
                end else begin
                    wr_en      = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            ilst_pkg::CMD_INSERT: begin
                if (pos_x > cnt_x) begin
                    status = ilst_pkg::ST_RANGE;
                end else if (full) begin
                    status = ilst_pkg::ST_FULL;
                end else begin
                    wr_en      = accept;
                    wr_pos     = CW'(pos_x);
                    count_next = count_reg + CW'(1);
                end
            end
            ilst_pkg::CMD_REMOVE: begin
                if (count_reg == '0) begin
                    status = ilst_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            ilst_pkg::CMD_READ: begin
                if (count_reg == '0) begin
                    status = ilst_pkg::ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    status = ilst_pkg::ST_RANGE;
                end else begin
                    rd_value = rd_bus;
                end
            end
            default: begin
                status = ilst_pkg::ST_OK;
            end
        endcase
    end

    // Output register next values.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next              = 1'b1;
            m_data_next.read_value    = rd_value;
            m_data_next.element_count = CO_W'(count_next);
            m_data_next.status        = status;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state with synchronous reset; result payload without.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: src/ilst_cell.sv
// ----------------------------------------------------------------------------
// ilst_cell
// One entry of the list. On a write it either takes the new value (when it
// sits at the write position) or takes its lower neighbor's entry (when it
// sits above the write position), so an insert shifts the upper part of the
// list by one place in the same clock as the new value is written.
// ----------------------------------------------------------------------------
module ilst_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [CW-1:0]                       wr_pos,
    input  logic signed [ilst_pkg::DATA_W-1:0]  wr_value,
    input  logic signed [ilst_pkg::DATA_W-1:0]  left_value,
    input  logic [ilst_pkg::POS_W-1:0]          rd_pos,
    output logic signed [ilst_pkg::DATA_W-1:0]  entry_out,
    output logic signed [ilst_pkg::DATA_W-1:0]  rd_word
);

    localparam logic [CW-1:0] IDX    = CW'(INDEX);
    localparam bit            RD_OK  = (INDEX < (2 ** ilst_pkg::POS_W));

    logic signed [ilst_pkg::DATA_W-1:0] entry_reg;
    logic signed [ilst_pkg::DATA_W-1:0] entry_next;

    // Select the new entry: hold, take the written word, or shift up.
    always_comb begin
        entry_next = entry_reg;
        if (wr_en) begin
            if (IDX == wr_pos) begin
                entry_next = wr_value;
            end else if (IDX > wr_pos) begin
                entry_next = left_value;
            end
        end
    end

    // Entry storage needs no reset; only written entries are ever read.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

    // Drive the entry onto the read bus only when this cell is addressed.
    assign rd_word = (RD_OK && (rd_pos == ilst_pkg::POS_W'(INDEX))) ? entry_reg : '0;

endmodule
